### src/assert_macros.svh
// Assertion macros shared by the position move controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

### src/pdmc_pkg.sv
// Package for the position move controller: widths, constants, codes,
// sequencer state type and the command/status structs of the serial units.
// Depends on nothing.
package pdmc_pkg;

   // Default encoder resolution and angle units per revolution
   localparam int COUNTS_PER_REV_DEF  = 960;
   localparam int ANGLE_UNITS_PER_REV = 5760;

   // Field widths
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 32;
   localparam int TIME_W  = 32;
   localparam int ERR_W   = 33;
   localparam int DELTA_W = 34;
   localparam int DUTY_W  = 8;
   localparam int DIR_W   = 2;

   // Configuration registers
   localparam int DB_W       = 8;
   localparam int KP_W       = 16;
   localparam int KD_W       = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DEADBAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_KP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_KD       = 2'd2;

   localparam logic [DB_W-1:0] DB_RESET = 8'd3;
   localparam logic [KP_W-1:0] KP_RESET = 16'd190;
   localparam logic [KD_W-1:0] KD_RESET = 10'd10;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   // Serial multiplier: multiplicand, multiplier and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Serial divider: dividend/quotient, divisor and step counter widths
   localparam int DIV_N_W   = 60;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   // Speed scaling: Q16 sum, per-mille scale, duty by reciprocal of 1000
   localparam int SUM_W        = 62;
   localparam int Q16_W        = 16;
   localparam int SCALE_W      = 10;
   localparam int SCALE_FULL   = 1000;
   localparam int SCALE_PROD_W = Q16_W + SCALE_W;
   localparam int DUTY_FULL    = 255;
   localparam int DUTY_SHIFT   = 28;
   localparam int DUTY_RECIP   = DUTY_FULL * ((2**DUTY_SHIFT + SCALE_FULL - 1) / SCALE_FULL);
   localparam int DUTY_RECIP_W = 27;
   localparam int DUTY_PROD_W  = SCALE_W + DUTY_RECIP_W;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LAT_MUL,
      ST_LAT_MUL_WAIT,
      ST_LAT_DIV,
      ST_LAT_DIV_WAIT,
      ST_LATCH,
      ST_ERR,
      ST_CHECK,
      ST_P_MUL,
      ST_P_WAIT,
      ST_D_MUL,
      ST_D_WAIT,
      ST_Q_DIV,
      ST_Q_WAIT,
      ST_SUM,
      ST_MAG,
      ST_SCALE,
      ST_DUTY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_N_W-1:0]   dividend;
      logic [DIV_D_W-1:0]   divisor;
      logic [DIV_CNT_W-1:0] iters;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### src/pdmc_req_if.sv
// Request channel of the position move controller: one control tick.
// Depends on pdmc_pkg.
interface pdmc_req_if import pdmc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] move_angle;
   logic signed [POS_W-1:0]   encoder_count;
   logic        [TIME_W-1:0]  time_us;

   modport source (output valid, output move_angle, output encoder_count,
                   output time_us, input ready);
   modport sink   (input valid, input move_angle, input encoder_count,
                   input time_us, output ready);
endinterface

### src/pdmc_rsp_if.sv
// Response channel of the position move controller: duty, direction, done.
// Depends on pdmc_pkg.
interface pdmc_rsp_if import pdmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic [DIR_W-1:0]  direction;
   logic              move_done;

   modport source (output valid, output duty, output direction, output move_done,
                   input ready);
   modport sink   (input valid, input duty, input direction, input move_done,
                   output ready);
endinterface

### src/pdmc_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero. Depends on pdmc_pkg.
module pdmc_mul import pdmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mul_cmd_type        cmd,
   output mul_stat_type       stat,
   output logic [MUL_P_W-1:0] product
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_P_W-1:0] mcand_ff, mcand_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;

   // Load on start, then add and shift one bit a cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         mcand_in  = {{(MUL_P_W-MUL_A_W){1'b0}}, cmd.mcand};
         mplier_in = cmd.mplier;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         if (mplier_ff[MUL_B_W-1:1] == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

### src/pdmc_div.sv
// Restoring serial divider: one quotient bit per cycle for a given number
// of steps, dividend left-aligned by the caller. Depends on pdmc_pkg.
module pdmc_div import pdmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_cmd_type        cmd,
   output div_stat_type       stat,
   output logic [DIV_N_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_N_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   trial;

   // Bring in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, dvd_ff[DIV_N_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         dvd_in  = cmd.dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         // Keep the remainder when the trial borrows
         if (trial[DIV_D_W+1]) begin
            rem_in = shifted[DIV_D_W-1:0];
         end else begin
            rem_in = trial[DIV_D_W-1:0];
         end
         quo_in = {quo_ff[DIV_N_W-2:0], ~trial[DIV_D_W+1]};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### src/pd_position_move_controller.sv
// PD position move controller with deadband; uses pdmc_pkg, the channel
// interfaces, pdmc_mul and pdmc_div. One tick at a time: a moving tick may run
// the 60-step serial divider on the derivative term, and a latching tick adds
// up to 16 multiplier steps plus the 28-step rounding divide. The next tick
// is taken once the result sits in the output register. Synchronous reset.
`include "assert_macros.svh"

module pd_position_move_controller import pdmc_pkg::*; #(
   parameter int COUNTS_PER_REV = COUNTS_PER_REV_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pdmc_req_if.sink              req_ch,
   pdmc_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CPR_W  = $clog2(COUNTS_PER_REV + 1);
   localparam int LNUM_W = ANGLE_W + CPR_W + 2;
   localparam logic [MUL_A_W-1:0] CPR_K      = MUL_A_W'(COUNTS_PER_REV);
   localparam logic [LNUM_W-1:0]  ROUND_HALF = LNUM_W'(ANGLE_UNITS_PER_REV);
   localparam logic [DIV_D_W-1:0] ROUND_DIV  = DIV_D_W'(2 * ANGLE_UNITS_PER_REV);

   state_type state_ff, state_in;

   logic [DB_W-1:0] db_ff, db_in;
   logic [KP_W-1:0] kp_ff, kp_in;
   logic [KD_W-1:0] kd_ff, kd_in;

   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic        [TIME_W-1:0]  now_ff, now_in;

   logic                      move_active_ff, move_active_in;
   logic signed [POS_W-1:0]   target_ff, target_in;
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;
   logic        [TIME_W-1:0]  last_time_ff, last_time_in;

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic        [ERR_W-1:0]   errmag_ff, errmag_in;
   logic        [TIME_W-1:0]  dt_ff, dt_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [SUM_W-1:0]   p_ff, p_in;
   logic signed [SUM_W-1:0]   dq_ff, dq_in;
   logic signed [SUM_W-1:0]   s_ff, s_in;
   logic                      sat_ff, sat_in;
   logic        [Q16_W-1:0]   sml_ff, sml_in;
   logic        [SCALE_W-1:0] s1000_ff, s1000_in;

   logic [DUTY_W-1:0] res_duty_ff, res_duty_in;
   logic [DIR_W-1:0]  res_dir_ff, res_dir_in;
   logic              res_done_ff, res_done_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic [DIR_W-1:0]  rsp_dir_ff, rsp_dir_in;
   logic              rsp_done_ff, rsp_done_in;

   mul_cmd_type        mul_cmd;
   mul_stat_type       mul_stat;
   logic [MUL_P_W-1:0] mul_product;
   div_cmd_type        div_cmd;
   div_stat_type       div_stat;
   logic [DIV_N_W-1:0] div_quo;

   logic [POS_W:0]              pos_sum;
   logic [ANGLE_W-1:0]          angle_mag;
   logic [LNUM_W-1:0]           lat_num;
   logic [DELTA_W-1:0]          lat_q;
   logic signed [DELTA_W-1:0]   lat_diff;
   logic [ERR_W-1:0]            err_mag;
   logic                        moving;
   logic [DELTA_W-1:0]          delta_mag;
   logic [SUM_W-1:0]            p_ext;
   logic [SUM_W-1:0]            q_ext;
   logic [SUM_W-1:0]            s_mag;
   logic [SCALE_PROD_W-1:0]     scale_prod;
   logic [DUTY_PROD_W-1:0]      duty_prod;
   logic                        rsp_free;

   // Serial arithmetic units
   pdmc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .stat    (mul_stat),
      .product (mul_product)
   );

   pdmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Halve the encoder count, truncating toward zero
   assign pos_sum = {req_ch.encoder_count[POS_W-1], req_ch.encoder_count}
                  + {{POS_W{1'b0}}, req_ch.encoder_count[POS_W-1]};

   // Magnitudes and scaled values feeding the sequencer
   assign angle_mag = angle_ff[ANGLE_W-1] ? (~$unsigned(angle_ff) + ANGLE_W'(1))
                                          : $unsigned(angle_ff);
   assign lat_num   = {1'b0, mul_product[ANGLE_W+CPR_W-1:0], 1'b0} + ROUND_HALF;
   assign lat_q     = div_quo[DELTA_W-1:0];
   assign lat_diff  = angle_ff[ANGLE_W-1] ? -$signed(lat_q) : $signed(lat_q);
   assign err_mag   = err_ff[ERR_W-1] ? (~$unsigned(err_ff) + ERR_W'(1))
                                      : $unsigned(err_ff);
   assign moving    = err_mag > {{(ERR_W-DB_W){1'b0}}, db_ff};
   assign delta_mag = delta_ff[DELTA_W-1] ? (~$unsigned(delta_ff) + DELTA_W'(1))
                                          : $unsigned(delta_ff);
   assign p_ext     = {{(SUM_W-MUL_P_W){1'b0}}, mul_product};
   assign q_ext     = {{(SUM_W-DIV_N_W){1'b0}}, div_quo};
   assign s_mag     = s_ff[SUM_W-1] ? (~$unsigned(s_ff) + SUM_W'(1)) : $unsigned(s_ff);
   assign scale_prod = SCALE_PROD_W'(sml_ff) * SCALE_PROD_W'(SCALE_FULL);
   assign duty_prod  = DUTY_PROD_W'(s1000_ff) * DUTY_PROD_W'(DUTY_RECIP);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = move_active_ff ? ST_ERR : ST_LAT_MUL;
            end
         end
         ST_LAT_MUL:      state_in = ST_LAT_MUL_WAIT;
         ST_LAT_MUL_WAIT: if (mul_stat.done) state_in = ST_LAT_DIV;
         ST_LAT_DIV:      state_in = ST_LAT_DIV_WAIT;
         ST_LAT_DIV_WAIT: if (div_stat.done) state_in = ST_LATCH;
         ST_LATCH:        state_in = ST_ERR;
         ST_ERR:          state_in = ST_CHECK;
         ST_CHECK:        state_in = moving ? ST_P_MUL : ST_OUT;
         ST_P_MUL:        state_in = ST_P_WAIT;
         ST_P_WAIT:       if (mul_stat.done) state_in = ST_D_MUL;
         ST_D_MUL:        state_in = ST_D_WAIT;
         ST_D_WAIT: begin
            if (mul_stat.done) begin
               if (dt_ff == '0 || mul_product == '0) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_Q_DIV;
               end
            end
         end
         ST_Q_DIV:        state_in = ST_Q_WAIT;
         ST_Q_WAIT:       if (div_stat.done) state_in = ST_SUM;
         ST_SUM:          state_in = ST_MAG;
         ST_MAG:          state_in = ST_SCALE;
         ST_SCALE:        state_in = ST_DUTY;
         ST_DUTY:         state_in = ST_OUT;
         ST_OUT:          if (rsp_free) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit commands
   always_comb begin
      db_in          = db_ff;
      kp_in          = kp_ff;
      kd_in          = kd_ff;
      angle_in       = angle_ff;
      pos_in         = pos_ff;
      now_in         = now_ff;
      move_active_in = move_active_ff;
      target_in      = target_ff;
      last_err_in    = last_err_ff;
      last_time_in   = last_time_ff;
      err_in         = err_ff;
      errmag_in      = errmag_ff;
      dt_in          = dt_ff;
      delta_in       = delta_ff;
      p_in           = p_ff;
      dq_in          = dq_ff;
      s_in           = s_ff;
      sat_in         = sat_ff;
      sml_in         = sml_ff;
      s1000_in       = s1000_ff;
      res_duty_in    = res_duty_ff;
      res_dir_in     = res_dir_ff;
      res_done_in    = res_done_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_done_in    = rsp_done_ff;
      mul_cmd        = '0;
      div_cmd        = '0;

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IDX_DEADBAND: db_in = csr_wdata[DB_W-1:0];
            CSR_IDX_KP:       kp_in = csr_wdata[KP_W-1:0];
            CSR_IDX_KD:       kd_in = csr_wdata[KD_W-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            angle_in = req_ch.move_angle;
            pos_in   = $signed(pos_sum[POS_W:1]);
            now_in   = req_ch.time_us;
         end
         ST_LAT_MUL: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = CPR_K;
            mul_cmd.mplier = angle_mag;
         end
         ST_LAT_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {lat_num, {(DIV_N_W-LNUM_W){1'b0}}};
            div_cmd.divisor  = ROUND_DIV;
            div_cmd.iters    = DIV_CNT_W'(LNUM_W);
         end
         ST_LATCH: begin
            // Latch the new target relative to the current position
            move_active_in = 1'b1;
            target_in      = POS_W'(lat_diff + DELTA_W'(pos_ff));
            last_err_in    = ERR_W'(lat_diff);
            last_time_in   = now_ff;
         end
         ST_ERR: begin
            err_in       = ERR_W'(target_ff) - ERR_W'(pos_ff);
            dt_in        = now_ff - last_time_ff;
            last_time_in = now_ff;
         end
         ST_CHECK: begin
            errmag_in   = err_mag;
            delta_in    = DELTA_W'(last_err_ff) - DELTA_W'(err_ff);
            last_err_in = err_ff;
            if (moving) begin
               res_dir_in  = err_ff[ERR_W-1] ? DIR_BACK : DIR_FWD;
               res_done_in = 1'b0;
            end else begin
               // Inside the deadband: stop and end the move
               move_active_in = 1'b0;
               res_duty_in    = '0;
               res_dir_in     = DIR_STOP;
               res_done_in    = 1'b1;
            end
         end
         ST_P_MUL: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = {1'b0, errmag_ff};
            mul_cmd.mplier = kp_ff;
         end
         ST_P_WAIT: begin
            p_in = err_ff[ERR_W-1] ? -$signed(p_ext) : $signed(p_ext);
         end
         ST_D_MUL: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.mcand  = delta_mag;
            mul_cmd.mplier = {{(MUL_B_W-KD_W){1'b0}}, kd_ff};
         end
         ST_D_WAIT: begin
            dq_in = '0;
         end
         ST_Q_DIV: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {mul_product[DIV_N_W-Q16_W-1:0], {Q16_W{1'b0}}};
            div_cmd.divisor  = dt_ff;
            div_cmd.iters    = DIV_CNT_W'(DIV_N_W);
         end
         ST_Q_WAIT: begin
            dq_in = delta_ff[DELTA_W-1] ? -$signed(q_ext) : $signed(q_ext);
         end
         ST_SUM: begin
            s_in = p_ff + dq_ff;
         end
         ST_MAG: begin
            sat_in = |s_mag[SUM_W-1:Q16_W];
            sml_in = s_mag[Q16_W-1:0];
         end
         ST_SCALE: begin
            s1000_in = sat_ff ? SCALE_W'(SCALE_FULL) : scale_prod[SCALE_PROD_W-1:Q16_W];
         end
         ST_DUTY: begin
            res_duty_in = duty_prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
         end
         ST_OUT: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = res_duty_ff;
               rsp_dir_in   = res_dir_ff;
               rsp_done_in  = res_done_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         db_ff          <= DB_RESET;
         kp_ff          <= KP_RESET;
         kd_ff          <= KD_RESET;
         move_active_ff <= 1'b0;
         target_ff      <= '0;
         last_err_ff    <= '0;
         last_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         db_ff          <= db_in;
         kp_ff          <= kp_in;
         kd_ff          <= kd_in;
         move_active_ff <= move_active_in;
         target_ff      <= target_in;
         last_err_ff    <= last_err_in;
         last_time_ff   <= last_time_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      pos_ff      <= pos_in;
      now_ff      <= now_in;
      err_ff      <= err_in;
      errmag_ff   <= errmag_in;
      dt_ff       <= dt_in;
      delta_ff    <= delta_in;
      p_ff        <= p_in;
      dq_ff       <= dq_in;
      s_ff        <= s_in;
      sat_ff      <= sat_in;
      sml_ff      <= sml_in;
      s1000_ff    <= s1000_in;
      res_duty_ff <= res_duty_in;
      res_dir_ff  <= res_dir_in;
      res_done_ff <= res_done_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.duty      = rsp_duty_ff;
   assign rsp_ch.direction = rsp_dir_ff;
   assign rsp_ch.move_done = rsp_done_ff;

   // Checks on the sequencer and the serial units
   `ASSERT_NEXT(a_one_tick_at_a_time, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASSERT_IMPLIES(a_mul_start_idle, clock, reset, mul_cmd.start, !mul_stat.busy)
   `ASSERT_IMPLIES(a_div_start_ok, clock, reset, div_cmd.start, !div_stat.busy && div_cmd.divisor != '0)
   `ASSERT_IMPLIES(a_moving_has_dir, clock, reset, rsp_ch.valid && !rsp_ch.move_done, rsp_ch.direction == DIR_FWD || rsp_ch.direction == DIR_BACK)

endmodule
